// ===== hdl/cfp_pkg.sv =====
// cfp_pkg: shared types, header codes and frame lengths for the command frame parser
// no dependencies
`timescale 1ns / 1ps

package cfp_pkg;

    localparam logic [7:0] HDR_ID    = 8'hFC;
    localparam logic [7:0] HDR_MIN   = 8'hFD;
    localparam logic [7:0] HDR_CLOCK = 8'hFE;

    // position of the checksum byte in each frame kind
    localparam logic [3:0] LAST_ID    = 4'd3;
    localparam logic [3:0] LAST_MIN   = 4'd2;
    localparam logic [3:0] LAST_CLOCK = 4'd9;

    localparam logic [7:0] LIMIT_RESET = 8'd60;

    typedef enum logic [1:0] {
        KIND_ID    = 2'd0,
        KIND_MIN   = 2'd1,
        KIND_CLOCK = 2'd2
    } frame_kind_t;

    typedef struct packed {
        frame_kind_t frame_kind;
        logic [7:0]  system_id;
        logic [7:0]  parameter_id;
        logic [7:0]  record_minutes;
        logic [63:0] clock_bytes;
    } result_t;

    function automatic logic [3:0] last_pos(input frame_kind_t kind);
        logic [3:0] pos;
        pos = LAST_CLOCK;
        unique case (kind)
            KIND_ID:    pos = LAST_ID;
            KIND_MIN:   pos = LAST_MIN;
            KIND_CLOCK: pos = LAST_CLOCK;
            default:    pos = LAST_CLOCK;
        endcase
        return pos;
    endfunction

endpackage

// ===== hdl/cfp_rx_if.sv =====
// cfp_rx_if: received byte channel, valid/ready handshake
// no dependencies
`timescale 1ns / 1ps

interface cfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/cfp_res_if.sv =====
// cfp_res_if: decoded frame result channel, valid/ready handshake
// depends on cfp_pkg
`timescale 1ns / 1ps

interface cfp_res_if;
    logic                valid;
    logic                ready;
    cfp_pkg::frame_kind_t frame_kind;
    logic [7:0]          system_id;
    logic [7:0]          parameter_id;
    logic [7:0]          record_minutes;
    logic [63:0]         clock_bytes;

    modport source (output valid, output frame_kind, output system_id, output parameter_id,
                    output record_minutes, output clock_bytes, input ready);
    modport sink (input valid, input frame_kind, input system_id, input parameter_id,
                  input record_minutes, input clock_bytes, output ready);
endinterface

// ===== hdl/cfp_collector.sv =====
// cfp_collector: header hunt, byte collection and running checksum
// depends on cfp_pkg; produces a result strobe in the cycle of the checksum byte
`timescale 1ns / 1ps

module cfp_collector
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       in_byte,
    input  logic [7:0]       minutes_limit,
    output logic             res_fire,
    output cfp_pkg::result_t res
);

    logic [3:0]           count_reg;
    logic [3:0]           count_next;
    cfp_pkg::frame_kind_t kind_reg;
    cfp_pkg::frame_kind_t kind_next;
    logic [7:0]           sum_reg;
    logic [7:0]           sum_next;
    logic [63:0]          data_reg;
    logic [63:0]          data_next;
    logic [2:0]           data_idx;
    logic                 is_last;

    assign data_idx = 3'(count_reg - 4'd1);
    assign is_last  = (count_reg == cfp_pkg::last_pos(kind_reg));

    always_comb
    begin
        count_next = count_reg;
        kind_next  = kind_reg;
        sum_next   = sum_reg;
        data_next  = data_reg;
        res_fire   = 1'b0;
        if (in_fire)
        begin
            if (count_reg == 4'd0)
            begin
                sum_next = in_byte;
                case (in_byte)
                    cfp_pkg::HDR_ID:
                    begin
                        kind_next  = cfp_pkg::KIND_ID;
                        count_next = 4'd1;
                    end
                    cfp_pkg::HDR_MIN:
                    begin
                        kind_next  = cfp_pkg::KIND_MIN;
                        count_next = 4'd1;
                    end
                    cfp_pkg::HDR_CLOCK:
                    begin
                        kind_next  = cfp_pkg::KIND_CLOCK;
                        count_next = 4'd1;
                    end
                    default:
                    begin
                        count_next = 4'd0;
                    end
                endcase
            end
            else if (is_last)
            begin
                count_next = 4'd0;
                res_fire   = (sum_reg == in_byte);
            end
            else
            begin
                count_next               = count_reg + 4'd1;
                sum_next                 = sum_reg + in_byte;
                data_next[data_idx*8 +: 8] = in_byte;
            end
        end
    end

    always_comb
    begin
        res            = '0;
        res.frame_kind = kind_reg;
        unique case (kind_reg)
            cfp_pkg::KIND_ID:
            begin
                res.system_id    = data_reg[7:0];
                res.parameter_id = data_reg[15:8];
            end
            cfp_pkg::KIND_MIN:
            begin
                res.record_minutes = (data_reg[7:0] >= minutes_limit) ? minutes_limit
                                                                      : data_reg[7:0];
            end
            cfp_pkg::KIND_CLOCK:
            begin
                res.clock_bytes = data_reg;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd0;
            kind_reg  <= cfp_pkg::KIND_ID;
            sum_reg   <= 8'd0;
        end
        else
        begin
            count_reg <= count_next;
            kind_reg  <= kind_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== hdl/command_frame_parser_core.sv =====
// command_frame_parser_core: top level of the command frame parser
// depends on cfp_pkg, cfp_rx_if, cfp_res_if and cfp_collector
// a result is valid in the cycle after the transfer of the checksum byte
// throughput: one byte per cycle; the byte channel stalls only while a result waits unread
// reset: asynchronous active low; clears the frame state, empties the result register
// and sets the minutes limit to 60
`timescale 1ns / 1ps

module command_frame_parser_core
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    cfp_rx_if.sink    rx,
    cfp_res_if.source res
);

    logic [7:0]       minutes_limit_reg;
    logic             in_fire;
    logic             res_fire;
    cfp_pkg::result_t res_comb;
    cfp_pkg::result_t res_reg;
    logic             res_valid_reg;
    logic             res_valid_next;

    assign rx.ready  = !res_valid_reg || res.ready;
    assign in_fire   = rx.valid && rx.ready;

    cfp_collector u_collector
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .in_byte       (rx.rx_byte),
        .minutes_limit (minutes_limit_reg),
        .res_fire      (res_fire),
        .res           (res_comb)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (res_fire)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg     <= 1'b0;
            minutes_limit_reg <= cfp_pkg::LIMIT_RESET;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
            begin
                minutes_limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            res_reg <= res_comb;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.frame_kind     = res_reg.frame_kind;
    assign res.system_id      = res_reg.system_id;
    assign res.parameter_id   = res_reg.parameter_id;
    assign res.record_minutes = res_reg.record_minutes;
    assign res.clock_bytes    = res_reg.clock_bytes;

endmodule
